// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset
`define BTDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clk edge outside reset
`define BTDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/btds_pkg.sv -----
// Shared types and constants of the byte translate/delete/squeeze filter
package btds_pkg;

  localparam int unsigned TABLE_SIZE = 256;

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_ADD1   = 3'd1;
  localparam logic [2:0] OP_ADD2   = 3'd2;
  localparam logic [2:0] OP_BUILD  = 3'd3;
  localparam logic [2:0] OP_FILTER = 3'd4;

  localparam logic [1:0] REG_COMPLEMENT = 2'd0;
  localparam logic [1:0] REG_DELETE     = 2'd1;
  localparam logic [1:0] REG_SQUEEZE    = 2'd2;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_CLR,
    PH_MEMB,
    PH_PAD,
    PH_WORK,
    PH_SQZ
  } phase_t;

  typedef struct packed {
    logic   accept;
    logic   filt;
    phase_t phase;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic stall;
  } status_t;

endpackage

// ----- design/btds_if.sv -----
// Valid/ready channel interfaces for input items and result bytes
interface btds_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] value;
  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

interface btds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

// ----- design/btds_ctrl.sv -----
// Controller state machine: item acceptance, build sequencing, filter stage
module btds_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       operation,
  output logic             in_ready,
  output btds_pkg::cmd_t    cmd,
  input  btds_pkg::status_t status
);
  import btds_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FILT = 8'b0000_0010,
    S_CLR  = 8'b0000_0100,
    S_MEMB = 8'b0000_1000,
    S_PAD  = 8'b0001_0000,
    S_WORK = 8'b0010_0000,
    S_SQZ  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) || ((state == S_FILT) && !status.stall);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.accept = accept;
    cmd.filt   = (state == S_FILT);
    unique case (state)
      S_CLR:   cmd.phase = PH_CLR;
      S_MEMB:  cmd.phase = PH_MEMB;
      S_PAD:   cmd.phase = PH_PAD;
      S_WORK:  cmd.phase = PH_WORK;
      S_SQZ:   cmd.phase = PH_SQZ;
      default: cmd.phase = PH_NONE;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state) inside
      S_IDLE, S_FILT: begin
        if (accept) begin
          if (operation == OP_FILTER) state_next = S_FILT;
          else if (operation == OP_BUILD) state_next = S_CLR;
          else state_next = S_IDLE;
        end else if (!status.stall) begin
          state_next = S_IDLE;
        end
      end
      S_CLR:  state_next = S_MEMB;
      S_MEMB: if (status.walk_end) state_next = S_PAD;
      S_PAD:  if (status.walk_end) state_next = S_WORK;
      S_WORK: if (status.walk_end) state_next = S_SQZ;
      S_SQZ:  if (status.walk_end) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// ----- design/btds_dp.sv -----
// Datapath: set memories, translate table, masks, build walks and filter stage
module btds_dp #(
  parameter int unsigned SET_DEPTH = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  btds_pkg::cmd_t     cmd,
  output btds_pkg::status_t  status,
  input  logic [2:0]        operation,
  input  logic [7:0]        value,
  input  logic              complement_set,
  input  logic              delete_mode,
  input  logic              squeeze_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte
);
  import btds_pkg::*;

  localparam int unsigned AW = $clog2(SET_DEPTH);
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);

  logic [7:0]    s1_mem [SET_DEPTH];
  logic [7:0]    s2_mem [SET_DEPTH];
  logic [7:0]    tt_mem [TABLE_SIZE];
  logic [7:0]    s1_rd, s2_rd, tt_rd;
  logic [CW-1:0] n1, n2, idx, kcnt, kval, limit;
  logic [AW-1:0] s2_addr;
  logic [TABLE_SIZE-1:0] tt_vld, member, dmask, smask;
  logic [7:0]    pad, val_q, prev;
  logic          prev_valid;
  phase_t        st_phase;
  logic          st_valid, st_comp, st_kge;
  logic [7:0]    st_b;
  logic          walking, issue, work_en, add1, add2;
  logic [7:0]    ap_w, ap_d, c;
  logic          tt_we, result, load;

  assign walking = (cmd.phase == PH_MEMB) || (cmd.phase == PH_PAD) ||
                   (cmd.phase == PH_WORK) || (cmd.phase == PH_SQZ);

  always_comb begin
    case (cmd.phase)
      PH_MEMB: limit = n1;
      PH_PAD:  limit = CW'(1);
      PH_WORK: limit = complement_set ? CW'(TABLE_SIZE) : n1;
      PH_SQZ:  limit = (squeeze_mode && (n2 != '0)) ? n2 : '0;
      default: limit = '0;
    endcase
  end

  assign status.walk_end = (idx >= limit);
  assign issue   = walking && !status.walk_end;
  assign work_en = complement_set ? !member[idx[7:0]] : 1'b1;
  assign kval    = complement_set ? kcnt : idx;

  always_comb begin
    case (cmd.phase)
      PH_PAD:  s2_addr = AW'(n2 - CW'(1));
      PH_WORK: s2_addr = kval[AW-1:0];
      default: s2_addr = idx[AW-1:0];
    endcase
  end

  assign add1 = cmd.accept && (operation == OP_ADD1) && (n1 < CW'(SET_DEPTH));
  assign add2 = cmd.accept && (operation == OP_ADD2) && (n2 < CW'(SET_DEPTH));

  always_ff @(posedge clk) begin
    if (add1) s1_mem[n1[AW-1:0]] <= value;
    s1_rd <= s1_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (add2) s2_mem[n2[AW-1:0]] <= value;
    s2_rd <= s2_mem[s2_addr];
  end

  assign ap_w  = st_comp ? st_b : s1_rd;
  assign ap_d  = st_kge ? pad : s2_rd;
  assign tt_we = st_valid && (st_phase == PH_WORK) && !delete_mode && (n2 != '0);

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[ap_w] <= ap_d;
    if (cmd.accept && (operation == OP_FILTER)) tt_rd <= tt_mem[value];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1 <= '0;
      n2 <= '0;
    end else if (cmd.accept && (operation == OP_CLEAR)) begin
      n1 <= '0;
      n2 <= '0;
    end else begin
      if (add1) n1 <= n1 + CW'(1);
      if (add2) n2 <= n2 + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      kcnt     <= '0;
      st_valid <= 1'b0;
    end else begin
      if (issue) idx <= idx + CW'(1);
      else idx <= '0;
      if (cmd.phase == PH_CLR) kcnt <= '0;
      else if (issue && (cmd.phase == PH_WORK) && complement_set && work_en)
        kcnt <= kcnt + CW'(1);
      st_valid <= issue && ((cmd.phase != PH_WORK) || work_en);
    end
  end

  always_ff @(posedge clk) begin
    st_phase <= cmd.phase;
    st_comp  <= complement_set;
    st_kge   <= (kval >= n2);
    st_b     <= idx[7:0];
    if (cmd.accept) val_q <= value;
    if (st_valid && (st_phase == PH_PAD)) pad <= s2_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tt_vld <= '0;
      member <= '0;
      dmask  <= '0;
      smask  <= '0;
    end else if (cmd.phase == PH_CLR) begin
      tt_vld <= '0;
      member <= '0;
      dmask  <= '0;
      smask  <= '0;
    end else if (st_valid) begin
      case (st_phase)
        PH_MEMB: member[s1_rd] <= 1'b1;
        PH_WORK: begin
          if (delete_mode) dmask[ap_w] <= 1'b1;
          else begin
            if (n2 != '0) tt_vld[ap_w] <= 1'b1;
            else if (squeeze_mode) smask[ap_w] <= 1'b1;
          end
        end
        PH_SQZ:  smask[s2_rd] <= 1'b1;
        default: ;
      endcase
    end
  end

  assign c      = tt_vld[val_q] ? tt_rd : val_q;
  assign result = !dmask[val_q] &&
                  !(squeeze_mode && smask[c] && prev_valid && (prev == c));
  assign status.stall = cmd.filt && result && out_valid && !out_ready;
  assign load   = cmd.filt && result && !status.stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.phase == PH_CLR) prev_valid <= 1'b0;
      else if (load) prev_valid <= 1'b1;
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prev     <= c;
      out_byte <= c;
    end
  end

endmodule

// ----- design/byte_translate_delete_squeeze.sv -----
// Top level of the byte translate/delete/squeeze filter
//
//  channel | dir | transaction
//  din     | in  | operation[2:0], value[7:0]
//  dout    | out | out_byte[7:0]
//  apb     | in  | complement_set, delete_mode, squeeze_mode at 0x0/0x4/0x8
//
// Clear and add items return to idle; data bytes stream one per cycle through the
// translate-table memory read and a result register, stalling only when it is full.
// Build holds din.ready low in clear, set-one walk, pad, work walk (n1, or 256 with
// complement), set-two squeeze walk and done: walks use one read port per memory.
// Reset (rst, synchronous) sets an identity table and empty masks through valid bits.
module byte_translate_delete_squeeze #(
  parameter int unsigned SET_DEPTH = 512
) (
  input  logic          clk,
  input  logic          rst,
  btds_in_if.sink       din,
  btds_out_if.source    dout,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import btds_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    complement_set, delete_mode, squeeze_mode;
  logic    wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      complement_set <= 1'b0;
      delete_mode    <= 1'b0;
      squeeze_mode   <= 1'b0;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_COMPLEMENT: complement_set <= pwdata[0];
        REG_DELETE:     delete_mode    <= pwdata[0];
        REG_SQUEEZE:    squeeze_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_COMPLEMENT: prdata[0] = complement_set;
      REG_DELETE:     prdata[0] = delete_mode;
      REG_SQUEEZE:    prdata[0] = squeeze_mode;
      default: ;
    endcase
  end

  btds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .operation (din.operation),
    .in_ready  (din.ready),
    .cmd       (cmd),
    .status    (status)
  );

  btds_dp #(.SET_DEPTH(SET_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (din.operation),
    .value          (din.value),
    .complement_set (complement_set),
    .delete_mode    (delete_mode),
    .squeeze_mode   (squeeze_mode),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_byte       (dout.out_byte)
  );

endmodule

// ----- design/btds_chk.sv -----
// Port-level checker for the filter and its bind to the top level
`include "assert_macros.svh"

module btds_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic       pready
);
  import btds_pkg::*;

  logic filt_acc;

  assign filt_acc = in_valid && in_ready && (operation == OP_FILTER);

  `BTDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BTDS_ASSERT_IMP(a_out_src, $rose(out_valid), $past(filt_acc, 2))
  `BTDS_ASSERT_NXT(a_build_busy, in_valid && in_ready && (operation == OP_BUILD), !in_ready)
  `BTDS_ASSERT_IMP(a_pready, 1'b1, pready)

endmodule

bind byte_translate_delete_squeeze btds_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .operation (din.operation),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .pready    (pready)
);
